// ===== rtl/wbha_pkg.sv =====
`default_nettype none
package wbha_pkg;

	localparam int WARP_W        = 6;
	localparam int REG_W         = 16;
	localparam int LANE_W        = 7;
	localparam int NEED_W        = REG_W + 2;
	localparam int ADDR_W        = 3;
	localparam int DATA_W        = 32;
	localparam int IN_DATA_W     = 48;
	localparam int OUT_DATA_W    = 24;
	localparam int DEF_MAX_PARTS = 8;

	localparam logic [WARP_W-1:0] MAIN_WARPS_RST = WARP_W'(4);
	localparam logic [LANE_W-1:0] LANE_COUNT_RST = LANE_W'(32);
	localparam logic [REG_W-1:0]  EST_FLOOR      = REG_W'(40);
	localparam logic [REG_W-1:0]  EST_DEFAULT    = REG_W'(24);
	localparam longint            POOL_REGS      = 64'd65536;

	localparam logic [0:0] REG_MAIN_WARPS = 1'b0;
	localparam logic [0:0] REG_LANE_COUNT = 1'b1;

	typedef struct packed {
		logic [WARP_W-1:0] main_warps;
		logic [LANE_W-1:0] lane_count;
	} cfg_t;

	typedef struct packed {
		logic [WARP_W-1:0] orig;
		logic [WARP_W-1:0] cur;
		logic [WARP_W-1:0] floor_w;
		logic [REG_W-1:0]  peak;
		logic [REG_W-1:0]  sum;
		logic              mat;
	} entry_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_MUL_D,
		ST_MUL_N,
		ST_CMP,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/warp_budget_halving_allocator.sv =====
`default_nettype none
// Warp budget allocator for up to MAX_PARTS worker partitions.
// s_* carries one record per partition; s_tlast marks the final record of a
// batch. Records load at one per cycle while s_tready is high. The final
// record starts the halving search: each partition is tested in ST_SCAN,
// and one above its floor whose halving leaves a nonzero warp total goes
// through the shared multiplier (lane product, need product, compare) in
// ST_MUL_D, ST_MUL_N and ST_CMP. Every halving restarts the scan at the
// first partition. s_tready stays low during search and emit.
// m_* then gives one result per stored partition in load order, one per
// cycle while m_tready is high; m_tlast marks the final one. A result sits
// in an output register, so a stalled receiver only holds the emit, and the
// next batch loads while the final result still waits.
// The APB port sets main_warps (0x0) and lane_count (0x4); write only while
// idle. Records beyond MAX_PARTS are dropped.
// Reset returns both registers to 4 and 32, empties the batch and clears
// m_tvalid; stored partition data is not cleared.
module warp_budget_halving_allocator #(
	parameter int MAX_PARTS = wbha_pkg::DEF_MAX_PARTS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// warp_count[5:0], min_warps[11:6], peak_regs[27:12], total_regs[43:28],
	// has_matrix_op[44], zero fill
	input  wire logic [wbha_pkg::IN_DATA_W-1:0]     s_tdata,
	input  wire logic                               s_tlast,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// new_warps[5:0], reg_estimate[21:6], needs_relayout[22], zero fill
	output logic      [wbha_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                                    m_tlast,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [wbha_pkg::ADDR_W-1:0]        paddr,
	input  wire logic [wbha_pkg::DATA_W-1:0]        pwdata,
	output logic      [wbha_pkg::DATA_W-1:0]        prdata,
	output logic                                    pready
);
	import wbha_pkg::*;

	localparam int IW     = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
	localparam int CW     = $clog2(MAX_PARTS + 1);
	localparam int SUM_W  = $clog2(63 * MAX_PARTS + 1);
	localparam int TOT_W  = $clog2(63 * (MAX_PARTS + 1) + 1);
	localparam int DW     = LANE_W + TOT_W;
	localparam int PROD_W = NEED_W + DW;

	cfg_t   cfg;
	state_t state_q, state_nxt;
	entry_t wr_entry, rd;

	logic [CW-1:0]     cnt_q, cnt_nxt;
	logic [SUM_W-1:0]  sum_q, sum_nxt;
	logic [TOT_W-1:0]  total_q, nt;
	logic [IW-1:0]     idx_q, last_idx_q;
	logic [NEED_W-1:0] need_q, need;
	logic [WARP_W-1:0] half_q, half;
	logic [TOT_W-1:0]  nt_q;
	logic [LANE_W-1:0] lanes;
	logic [NEED_W-1:0] mul_a;
	logic [DW-1:0]     mul_b;
	logic [PROD_W-1:0] prod;

	logic accept, do_store, candidate, hit, at_last, out_load;
	logic mul_en, cur_we;

	logic [WARP_W-1:0] out_warps_q;
	logic [REG_W-1:0]  out_est_q, est;
	logic              out_relay_q, out_last_q, m_tvalid_q, relay;

	wbha_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign accept   = s_tvalid && s_tready;
	assign do_store = accept && (cnt_q < CW'(MAX_PARTS));
	assign cnt_nxt  = do_store ? cnt_q + CW'(1) : cnt_q;
	assign sum_nxt  = do_store ? sum_q + SUM_W'(s_tdata[5:0]) : sum_q;

	always_comb begin
		wr_entry.orig    = s_tdata[5:0];
		wr_entry.cur     = s_tdata[5:0];
		wr_entry.floor_w = (s_tdata[11:6] == '0) ? WARP_W'(1) : s_tdata[11:6];
		wr_entry.peak    = s_tdata[27:12];
		wr_entry.sum     = s_tdata[43:28];
		wr_entry.mat     = s_tdata[44];
	end

	wbha_store #(
		.MAX_PARTS (MAX_PARTS),
		.IW        (IW)
	) u_store (
		.clk       (clk),
		.we        (do_store),
		.waddr     (cnt_q[IW-1:0]),
		.wdata     (wr_entry),
		.cur_we    (cur_we),
		.cur_wdata (half_q),
		.raddr     (idx_q),
		.rdata     (rd)
	);

	assign lanes     = (cfg.lane_count == '0) ? LANE_W'(1) : cfg.lane_count;
	assign half      = rd.cur >> 1;
	assign need      = (NEED_W'(rd.peak) << 1) +
		((rd.cur == WARP_W'(3)) ? NEED_W'(rd.peak) : '0);
	assign nt        = total_q - TOT_W'(half);
	assign candidate = (rd.cur > rd.floor_w) && (nt != '0);
	assign hit       = (64'(prod) <= POOL_REGS);
	assign at_last   = (idx_q == last_idx_q);
	assign out_load  = !m_tvalid_q || m_tready;

	assign mul_a = (state_q == ST_MUL_D) ? NEED_W'(lanes) : need_q;
	assign mul_b = (state_q == ST_MUL_D) ? DW'(nt_q) : prod[DW-1:0];

	wbha_mul #(
		.A_W (NEED_W),
		.B_W (DW)
	) u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_LOAD:  if (accept && s_tlast) state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (candidate)    state_nxt = ST_MUL_D;
				else if (at_last) state_nxt = ST_EMIT;
			end
			ST_MUL_D: state_nxt = ST_MUL_N;
			ST_MUL_N: state_nxt = ST_CMP;
			ST_CMP: begin
				if (hit)          state_nxt = ST_SCAN;
				else if (at_last) state_nxt = ST_EMIT;
				else              state_nxt = ST_SCAN;
			end
			ST_EMIT:  if (out_load && at_last) state_nxt = ST_LOAD;
			default:  state_nxt = ST_LOAD;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_LOAD);
		mul_en   = (state_q == ST_MUL_D) || (state_q == ST_MUL_N);
		cur_we   = (state_q == ST_CMP) && hit;
	end

	always_comb begin
		if (rd.sum != '0) begin
			est = (rd.sum > EST_FLOOR) ? rd.sum : EST_FLOOR;
		end else if (rd.mat) begin
			est = EST_FLOOR;
		end else begin
			est = EST_DEFAULT;
		end
		relay = (rd.cur != rd.orig) && ((rd.peak != '0) || rd.mat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			sum_q      <= '0;
			idx_q      <= '0;
			last_idx_q <= '0;
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						cnt_q <= cnt_nxt;
						sum_q <= sum_nxt;
						if (s_tlast) begin
							last_idx_q <= IW'(cnt_nxt - CW'(1));
							total_q    <= TOT_W'(cfg.main_warps) + TOT_W'(sum_nxt);
							idx_q      <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (!candidate) idx_q <= at_last ? '0 : idx_q + IW'(1);
				end
				ST_CMP: begin
					if (hit) begin
						total_q <= total_q - TOT_W'(half_q);
						idx_q   <= '0;
					end else begin
						idx_q <= at_last ? '0 : idx_q + IW'(1);
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (at_last) begin
							idx_q <= '0;
							cnt_q <= '0;
							sum_q <= '0;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				default: ;
			endcase
			if ((state_q == ST_EMIT) && out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			need_q <= need;
			half_q <= half;
			nt_q   <= nt;
		end
		if ((state_q == ST_EMIT) && out_load) begin
			out_warps_q <= rd.cur;
			out_est_q   <= est;
			out_relay_q <= relay;
			out_last_q  <= at_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_relay_q, out_est_q, out_warps_q};
	assign m_tlast  = out_last_q;

	a_halve_above_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cur_we |-> (rd.cur > rd.floor_w) && (half_q == (rd.cur >> 1)))
		else $error("halving a partition at or below its floor");

	a_search_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && hit) |-> (total_q > TOT_W'(half_q)))
		else $error("warp total would reach zero");

	a_batch_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && state_nxt == ST_LOAD) |=> (cnt_q == '0) && m_tvalid)
		else $error("batch not cleared after final result");

	a_no_emit_while_loading: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && !$past(state_q == ST_EMIT)) && m_tvalid && m_tready
			|=> !m_tvalid)
		else $error("result emitted outside the emit phase");

endmodule
`default_nettype wire

// ===== rtl/wbha_regs.sv =====
`default_nettype none
module wbha_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [wbha_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [wbha_pkg::DATA_W-1:0]   pwdata,
	output logic      [wbha_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,
	output wbha_pkg::cfg_t                     cfg
);
	import wbha_pkg::*;

	logic [WARP_W-1:0] main_warps_q;
	logic [LANE_W-1:0] lane_count_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_warps_q <= MAIN_WARPS_RST;
			lane_count_q <= LANE_COUNT_RST;
		end else if (wr_en) begin
			unique case (paddr[ADDR_W-1])
				REG_MAIN_WARPS: main_warps_q <= pwdata[WARP_W-1:0];
				REG_LANE_COUNT: lane_count_q <= pwdata[LANE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[ADDR_W-1])
			REG_MAIN_WARPS: prdata = DATA_W'(main_warps_q);
			REG_LANE_COUNT: prdata = DATA_W'(lane_count_q);
		endcase
	end

	assign cfg.main_warps = main_warps_q;
	assign cfg.lane_count = lane_count_q;

endmodule
`default_nettype wire

// ===== rtl/wbha_store.sv =====
`default_nettype none
module wbha_store #(
	parameter int MAX_PARTS = wbha_pkg::DEF_MAX_PARTS,
	parameter int IW        = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1
) (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [IW-1:0]                  waddr,
	input  wire wbha_pkg::entry_t               wdata,
	input  wire logic                           cur_we,
	input  wire logic [wbha_pkg::WARP_W-1:0]    cur_wdata,
	input  wire logic [IW-1:0]                  raddr,
	output wbha_pkg::entry_t                    rdata
);
	import wbha_pkg::*;

	entry_t mem_q [MAX_PARTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end else if (cur_we) begin
			mem_q[raddr].cur <= cur_wdata;
		end
	end

	assign rdata = mem_q[raddr];

endmodule
`default_nettype wire

// ===== rtl/wbha_mul.sv =====
`default_nettype none
module wbha_mul #(
	parameter int A_W = wbha_pkg::NEED_W,
	parameter int B_W = 18
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [A_W-1:0]       a,
	input  wire logic [B_W-1:0]       b,
	output logic      [A_W+B_W-1:0]   prod
);
	logic [A_W+B_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
		end
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import wbha_pkg::*;

	localparam int PARTS = DEF_MAX_PARTS;

	typedef struct packed {
		logic [WARP_W-1:0] warps;
		logic [WARP_W-1:0] min_w;
		logic [REG_W-1:0]  peak;
		logic [REG_W-1:0]  total;
		logic              mat;
		logic              last;
	} part_rec_t;

	typedef struct packed {
		logic [WARP_W-1:0] warps;
		logic [REG_W-1:0]  est;
		logic              relay;
		logic              last;
	} alloc_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	warp_budget_halving_allocator #(.MAX_PARTS(PARTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	logic [WARP_W-1:0] cfg_main = MAIN_WARPS_RST;
	logic [LANE_W-1:0] cfg_lanes = LANE_COUNT_RST;

	logic [WARP_W-1:0] orig_w [PARTS];
	logic [WARP_W-1:0] cur_w [PARTS];
	logic [WARP_W-1:0] floor_w [PARTS];
	logic [REG_W-1:0]  peak_r [PARTS];
	logic [REG_W-1:0]  sum_r [PARTS];
	logic              mat_r [PARTS];
	int unsigned       n_stored = 0;

	part_rec_t  rec_queue[$];
	alloc_res_t alloc_exp[$];
	part_rec_t  offered = '0;
	part_rec_t  nxt;

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int errors = 0;
	int n_records = 0;
	int n_batches = 0;
	int n_halvings = 0;
	int n_results = 0;

	function automatic bit try_halve();
		int unsigned total, lanes, w, half, need, share;
		total = cfg_main;
		lanes = (cfg_lanes == 0) ? 1 : cfg_lanes;
		for (int i = 0; i < n_stored; i++)
			total += cur_w[i];
		for (int i = 0; i < n_stored; i++) begin
			w = cur_w[i];
			if (w <= floor_w[i])
				continue;
			half = w / 2;
			need = peak_r[i] * (w / half);
			if (total - half == 0)
				continue;
			share = int'(POOL_REGS / lanes / (total - half));
			if (need <= share) begin
				cur_w[i] = half;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic budget_absorb(part_rec_t r);
		alloc_res_t res;
		n_records++;
		if (n_stored < PARTS) begin
			orig_w[n_stored] = r.warps;
			cur_w[n_stored] = r.warps;
			floor_w[n_stored] = (r.min_w == 0) ? WARP_W'(1) : r.min_w;
			peak_r[n_stored] = r.peak;
			sum_r[n_stored] = r.total;
			mat_r[n_stored] = r.mat;
			n_stored++;
		end
		if (!r.last)
			return;
		while (try_halve())
			n_halvings++;
		for (int i = 0; i < n_stored; i++) begin
			res.warps = cur_w[i];
			if (sum_r[i] != 0)
				res.est = (sum_r[i] > EST_FLOOR) ? sum_r[i] : EST_FLOOR;
			else
				res.est = mat_r[i] ? EST_FLOOR : EST_DEFAULT;
			res.relay = (cur_w[i] != orig_w[i]) && (peak_r[i] != 0 || mat_r[i]);
			res.last = (i + 1 == n_stored);
			alloc_exp = {alloc_exp, res};
		end
		n_stored = 0;
		n_batches++;
	endtask

	// sender
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			budget_absorb(offered);
		if (!s_tvalid || s_tready) begin
			if (rec_queue.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				nxt = rec_queue.pop_front();
				offered <= nxt;
				s_tvalid <= 1'b1;
				s_tdata <= {3'b000, nxt.mat, nxt.total, nxt.peak, nxt.min_w, nxt.warps};
				s_tlast <= nxt.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			n_results++;
			if (alloc_exp.size() == 0) begin
				if (errors < 10)
					$display("unexpected result: warps=%0d est=%0d relay=%0b last=%0b",
						m_tdata[5:0], m_tdata[21:6], m_tdata[22], m_tlast);
				errors++;
			end else if (m_tdata[5:0] !== alloc_exp[0].warps ||
					m_tdata[21:6] !== alloc_exp[0].est ||
					m_tdata[22] !== alloc_exp[0].relay ||
					m_tlast !== alloc_exp[0].last) begin
				if (errors < 10) begin
					$display("mismatch: exp warps=%0d est=%0d relay=%0b last=%0b",
						alloc_exp[0].warps, alloc_exp[0].est, alloc_exp[0].relay,
						alloc_exp[0].last);
					$display("          got warps=%0d est=%0d relay=%0b last=%0b",
						m_tdata[5:0], m_tdata[21:6], m_tdata[22], m_tlast);
				end
				errors++;
				void'(alloc_exp.pop_front());
			end else begin
				void'(alloc_exp.pop_front());
			end
		end
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 400;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	task automatic apb_write(logic [0:0] idx, logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_MAIN_WARPS)
			cfg_main = value[WARP_W-1:0];
		else
			cfg_lanes = value[LANE_W-1:0];
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (rec_queue.size() != 0 || s_tvalid || alloc_exp.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic add_rec(int w, int m, int p, int t, bit mat, bit last);
		part_rec_t r;
		r = '{WARP_W'(w), WARP_W'(m), REG_W'(p), REG_W'(t), mat, last};
		rec_queue = {rec_queue, r};
	endtask

	initial begin
		int set_main [6];
		int set_lanes [6];
		int left, n, w, m, p, t, sel;
		set_main = '{4, 1, 32, 0, 63, 17};
		set_lanes = '{32, 1, 64, 0, 127, 0};
		set_lanes[5] = $urandom_range(1, 64);
		snd_idle_pct = 29;
		rcv_idle_pct = 84;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		apb_write(REG_MAIN_WARPS, 4);
		apb_write(REG_LANE_COUNT, 32);
		add_rec(32, 1, 0, 0, 0, 1);
		add_rec(63, 0, 1, 65535, 1, 1);
		add_rec(0, 63, 65535, 39, 1, 1);
		add_rec(16, 4, 20, 40, 0, 0);
		add_rec(8, 8, 0, 0, 1, 0);
		add_rec(5, 1, 3, 41, 0, 1);
		for (int i = 0; i < 10; i++)
			add_rec(2 + 3 * i, 1 + (i % 3), 4 * i, 37 + i, i[0], i == 9);
		for (int i = 0; i < 8; i++)
			add_rec(1 << (i % 6), 1, i, 1000 * i, i[1], i == 7);
		wait_drained();

		for (int k = 0; k < 6; k++) begin
			snd_idle_pct = (k < 2) ? 29 : (k < 4) ? 84 : 0;
			rcv_idle_pct = (k < 2) ? 84 : (k < 4) ? 29 : 0;
			apb_write(REG_MAIN_WARPS, set_main[k]);
			apb_write(REG_LANE_COUNT, set_lanes[k]);
			left = 70;
			while (left > 0) begin
				n = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					sel = $urandom_range(9);
					if (sel < 5)
						w = 1 << $urandom_range(5);
					else if (sel < 9)
						w = $urandom_range(1, 32);
					else
						w = $urandom_range(63);
					sel = $urandom_range(9);
					m = (sel < 6) ? $urandom_range(1, (w < 1) ? 1 : w) :
						(sel < 8) ? 0 : $urandom_range(63);
					sel = $urandom_range(9);
					p = (sel < 5) ? $urandom_range(64) : (sel < 7) ? 0 :
						(sel < 9) ? $urandom_range(1000) : $urandom_range(65535);
					sel = $urandom_range(3);
					t = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(60) :
						$urandom_range(65535);
					add_rec(w, m, p, t, $urandom_range(1), i == n - 1);
				end
				left -= n;
			end
			if (k == 4)
				hold_req++;
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (alloc_exp.size() != 0)
			errors++;
		$display("Covered %0d records in %0d batches, %0d results, %0d halvings, 7 settings",
			n_records, n_batches, n_results, n_halvings);
		$display("Mismatches or missing results: %0d", errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout waiting for the allocator");
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/wbha_pkg.sv
rtl/wbha_regs.sv
rtl/wbha_store.sv
rtl/wbha_mul.sv
rtl/warp_budget_halving_allocator.sv
dv/tb.sv
